// ===== hw/rtl/wrcp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wrcp_pkg;

  localparam logic [31:0] ID_RIFF = 32'h5249_4646;
  localparam logic [31:0] ID_WAVE = 32'h5741_5645;
  localparam logic [31:0] ID_FMT = 32'h666D_7420;
  localparam logic [31:0] ID_DATA = 32'h6461_7461;
  localparam logic [31:0] FMT_BODY_LEN = 32'd16;
  localparam logic [15:0] PCM_FORMAT = 16'd1;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_BITS = 2'd2;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_BAD_MAGIC = 3'd1,
    ST_TRUNCATED = 3'd2,
    ST_FMT_SMALL = 3'd3,
    ST_UNSUPPORTED = 3'd4,
    ST_DATA_EARLY = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] pcm_byte;
    logic pcm_valid;
    logic done_res;
    status_t status;
  } result_t;

  typedef struct packed {
    logic [31:0] sample_rate;
    logic [15:0] channels;
    logic [15:0] sample_bits;
  } cfg_regs_t;

endpackage

`default_nettype wire

// ===== hw/rtl/wrcp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface wrcp_in_if;
  logic valid;
  logic ready;
  logic [7:0] file_byte;
  logic end_of_file;
  modport source (output valid, output file_byte, output end_of_file, input ready);
  modport sink (input valid, input file_byte, input end_of_file, output ready);
endinterface

interface wrcp_out_if;
  logic valid;
  logic ready;
  logic [7:0] pcm_byte;
  logic pcm_valid;
  logic done_res;
  logic [2:0] status;
  modport source (output valid, output pcm_byte, output pcm_valid, output done_res,
                  output status, input ready);
  modport sink (input valid, input pcm_byte, input pcm_valid, input done_res,
                input status, output ready);
endinterface

interface wrcp_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/wrcp_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wrcp_parser
  import wrcp_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic take,
  input wire logic [7:0] file_byte,
  input wire logic end_of_file,
  input wire cfg_regs_t cfg,
  output logic res_push,
  output result_t res
);

  typedef enum logic [2:0] {
    PH_RIFF,
    PH_CHUNK,
    PH_FMT_BODY,
    PH_FMT_TAIL,
    PH_SKIP,
    PH_DATA
  } phase_t;

  phase_t phase_r, phase_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic [63:0] shift_r, shift_nxt;
  logic [31:0] remain_r, remain_nxt;
  logic [15:0] format_r, format_nxt;
  logic [15:0] chans_r, chans_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic fmt_ok_r, fmt_ok_nxt;
  logic pad_r, pad_nxt;
  logic finished_r, finished_nxt;

  logic [63:0] sh_in;
  logic [31:0] size;
  logic [31:0] cons_rem;
  logic cons_pad;
  logic cons_done;
  logic fmt_match;
  logic st_v;
  status_t st;
  logic pcm_v;

  assign sh_in = {shift_r[55:0], file_byte};
  assign size = {sh_in[7:0], sh_in[15:8], sh_in[23:16], sh_in[31:24]};
  assign cons_rem = (remain_r != 32'd0) ? remain_r - 32'd1 : remain_r;
  assign cons_pad = (remain_r != 32'd0) ? pad_r : 1'b0;
  assign cons_done = (cons_rem == 32'd0) && !cons_pad;

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt = cnt_r;
    shift_nxt = shift_r;
    remain_nxt = remain_r;
    format_nxt = format_r;
    chans_nxt = chans_r;
    rate_nxt = rate_r;
    bits_nxt = bits_r;
    fmt_ok_nxt = fmt_ok_r;
    pad_nxt = pad_r;
    finished_nxt = finished_r;
    st_v = 1'b0;
    st = ST_OK;
    pcm_v = 1'b0;
    fmt_match = 1'b0;

    if (!finished_r) begin
      case (phase_r)
        PH_RIFF: begin
          shift_nxt = sh_in;
          cnt_nxt = cnt_r + 4'd1;
          if (cnt_nxt == 4'd8) begin
            shift_nxt = {63'd0, (sh_in[63:32] == ID_RIFF)};
          end
          if (cnt_nxt >= 4'd12) begin
            if (!(sh_in[32] && (sh_in[31:0] == ID_WAVE))) begin
              st_v = 1'b1;
              st = ST_BAD_MAGIC;
            end else begin
              phase_nxt = PH_CHUNK;
              cnt_nxt = 4'd0;
              shift_nxt = 64'd0;
            end
          end
        end
        PH_CHUNK: begin
          shift_nxt = sh_in;
          cnt_nxt = cnt_r + 4'd1;
          if (cnt_nxt == 4'd8) begin
            cnt_nxt = 4'd0;
            shift_nxt = 64'd0;
            pad_nxt = size[0];
            remain_nxt = size;
            if (sh_in[63:32] == ID_FMT) begin
              if (size < FMT_BODY_LEN) begin
                st_v = 1'b1;
                st = ST_FMT_SMALL;
              end else begin
                remain_nxt = size - FMT_BODY_LEN;
                format_nxt = 16'd0;
                chans_nxt = 16'd0;
                rate_nxt = 32'd0;
                bits_nxt = 16'd0;
                phase_nxt = PH_FMT_BODY;
              end
            end else if (sh_in[63:32] == ID_DATA) begin
              if (!fmt_ok_r) begin
                st_v = 1'b1;
                st = ST_DATA_EARLY;
              end else begin
                phase_nxt = PH_DATA;
                if (size == 32'd0) begin
                  st_v = 1'b1;
                  st = ST_OK;
                end
              end
            end else begin
              phase_nxt = (size == 32'd0) ? PH_CHUNK : PH_SKIP;
            end
          end
        end
        PH_FMT_BODY: begin
          if (cnt_r inside {[4'd0:4'd1]}) begin
            format_nxt[{cnt_r[0], 3'b000} +: 8] = file_byte;
          end else if (cnt_r inside {[4'd2:4'd3]}) begin
            chans_nxt[{cnt_r[0], 3'b000} +: 8] = file_byte;
          end else if (cnt_r inside {[4'd4:4'd7]}) begin
            rate_nxt[{cnt_r[1:0], 3'b000} +: 8] = file_byte;
          end else if (cnt_r inside {[4'd14:4'd15]}) begin
            bits_nxt[{cnt_r[0], 3'b000} +: 8] = file_byte;
          end
          if (cnt_r == 4'd15) begin
            cnt_nxt = 4'd0;
            phase_nxt = PH_FMT_TAIL;
            fmt_match = (remain_r == 32'd0) && !pad_r;
          end else begin
            cnt_nxt = cnt_r + 4'd1;
          end
        end
        PH_FMT_TAIL: begin
          remain_nxt = cons_rem;
          pad_nxt = cons_pad;
          fmt_match = cons_done;
        end
        PH_SKIP: begin
          remain_nxt = cons_rem;
          pad_nxt = cons_pad;
          if (cons_done) begin
            phase_nxt = PH_CHUNK;
          end
        end
        PH_DATA: begin
          pcm_v = (remain_r != 32'd0);
          remain_nxt = cons_rem;
          pad_nxt = cons_pad;
          if (cons_done) begin
            st_v = 1'b1;
            st = ST_OK;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase

      if (fmt_match) begin
        if ((format_nxt != PCM_FORMAT) || (chans_nxt != cfg.channels) ||
            (bits_nxt != cfg.sample_bits) || (rate_nxt != cfg.sample_rate)) begin
          st_v = 1'b1;
          st = ST_UNSUPPORTED;
        end else begin
          fmt_ok_nxt = 1'b1;
          phase_nxt = PH_CHUNK;
        end
      end

      if (end_of_file && !st_v) begin
        st_v = 1'b1;
        st = ST_TRUNCATED;
      end
    end

    if (end_of_file) begin
      phase_nxt = PH_RIFF;
      cnt_nxt = 4'd0;
      shift_nxt = 64'd0;
      remain_nxt = 32'd0;
      format_nxt = 16'd0;
      chans_nxt = 16'd0;
      rate_nxt = 32'd0;
      bits_nxt = 16'd0;
      fmt_ok_nxt = 1'b0;
      pad_nxt = 1'b0;
      finished_nxt = 1'b0;
    end else if (st_v) begin
      finished_nxt = 1'b1;
    end
  end

  assign res_push = take && (pcm_v || st_v);
  assign res.pcm_byte = pcm_v ? file_byte : 8'd0;
  assign res.pcm_valid = pcm_v;
  assign res.done_res = st_v;
  assign res.status = st_v ? st : ST_OK;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RIFF;
      cnt_r <= 4'd0;
      shift_r <= 64'd0;
      remain_r <= 32'd0;
      format_r <= 16'd0;
      chans_r <= 16'd0;
      rate_r <= 32'd0;
      bits_r <= 16'd0;
      fmt_ok_r <= 1'b0;
      pad_r <= 1'b0;
      finished_r <= 1'b0;
    end else if (take) begin
      phase_r <= phase_nxt;
      cnt_r <= cnt_nxt;
      shift_r <= shift_nxt;
      remain_r <= remain_nxt;
      format_r <= format_nxt;
      chans_r <= chans_nxt;
      rate_r <= rate_nxt;
      bits_r <= bits_nxt;
      fmt_ok_r <= fmt_ok_nxt;
      pad_r <= pad_nxt;
      finished_r <= finished_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/wrcp_obuf.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wrcp_obuf
  import wrcp_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic push,
  input wire result_t push_data,
  output logic can_take,
  output logic out_valid,
  input wire logic out_ready,
  output result_t out_data
);

  logic main_v_r;
  logic skid_v_r;
  result_t main_r;
  result_t skid_r;
  logic pop;

  assign pop = main_v_r && out_ready;
  assign can_take = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_data = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (pop) begin
      if (skid_v_r) begin
        main_r <= skid_r;
        skid_v_r <= 1'b0;
      end else begin
        main_v_r <= push;
        main_r <= push_data;
      end
    end else if (push) begin
      if (!main_v_r) begin
        main_v_r <= 1'b1;
        main_r <= push_data;
      end else begin
        skid_v_r <= 1'b1;
        skid_r <= push_data;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/wav_riff_chunk_parser.sv =====
// WAV stream parser. The file arrives on in_s, one byte per transaction,
// with end_of_file set on the last byte. Results leave on out_s: a
// forwarded data chunk byte (pcm_valid), the final status of the file
// (done_res with status), or both in one transaction. Bytes that produce
// no result produce no transaction.
// The required sample rate, channel count and sample width are written
// through cfg_s (index 0, 1 and 2); cfg_s is always ready.
// The parse state updates at the accepting edge, and any result is
// registered into the output buffer at that edge. The block sustains
// one byte per clock while the output buffer keeps in_s.ready high.
// A two-entry output buffer decouples the sides; in_s.ready drops only
// while both entries hold results the receiver has not taken, so a stall
// costs no result.
// Reset sets the configuration to 48000 Hz, 2 channels and 16 bits and
// returns the parser to the RIFF header. The byte that carries
// end_of_file re-arms the parser for the next file.
`timescale 1ns / 1ps
`default_nettype none

module wav_riff_chunk_parser
  import wrcp_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  wrcp_in_if.sink in_s,
  wrcp_out_if.source out_s,
  wrcp_cfg_if.sink cfg_s
);

  cfg_regs_t cfg_r;
  logic take;
  logic can_take;
  logic res_push;
  result_t res;
  result_t out_data;

  assign cfg_s.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_rate <= 32'd48000;
      cfg_r.channels <= 16'd2;
      cfg_r.sample_bits <= 16'd16;
    end else if (cfg_s.valid) begin
      case (cfg_s.index)
        REG_SAMPLE_RATE: cfg_r.sample_rate <= cfg_s.data;
        REG_CHANNELS: cfg_r.channels <= cfg_s.data[15:0];
        REG_SAMPLE_BITS: cfg_r.sample_bits <= cfg_s.data[15:0];
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  assign in_s.ready = can_take;
  assign take = in_s.valid && can_take;

  wrcp_parser u_parser (
    .clk(clk),
    .rst_n(rst_n),
    .take(take),
    .file_byte(in_s.file_byte),
    .end_of_file(in_s.end_of_file),
    .cfg(cfg_r),
    .res_push(res_push),
    .res(res)
  );

  wrcp_obuf u_obuf (
    .clk(clk),
    .rst_n(rst_n),
    .push(res_push),
    .push_data(res),
    .can_take(can_take),
    .out_valid(out_s.valid),
    .out_ready(out_s.ready),
    .out_data(out_data)
  );

  assign out_s.pcm_byte = out_data.pcm_byte;
  assign out_s.pcm_valid = out_data.pcm_valid;
  assign out_s.done_res = out_data.done_res;
  assign out_s.status = out_data.status;

endmodule

`default_nettype wire
